>>> src/jdar_pkg.sv
// Shared constants and types for the joystick dead-zone / auto-repeat unit.
// No dependencies; every other file depends on it.
`default_nettype none

package jdar_pkg;

   localparam int AdcBits = 10;

   localparam int CsrIndexBits = 3;
   localparam int CsrDataBits  = 16;

   // Configuration register indexes
   localparam logic [CsrIndexBits-1:0] CsrCentreX     = 3'd0;
   localparam logic [CsrIndexBits-1:0] CsrCentreY     = 3'd1;
   localparam logic [CsrIndexBits-1:0] CsrDeadzoneX   = 3'd2;
   localparam logic [CsrIndexBits-1:0] CsrDeadzoneY   = 3'd3;
   localparam logic [CsrIndexBits-1:0] CsrInitialWait = 3'd4;
   localparam logic [CsrIndexBits-1:0] CsrRepeatWait  = 3'd5;

   // Opcodes
   localparam logic OpEvaluate = 1'b0;
   localparam logic OpSetHold  = 1'b1;

   typedef logic [AdcBits-1:0]   sample_type;
   typedef logic [AdcBits-2:0]   deadzone_type;
   typedef logic [15:0]          wait_type;
   typedef logic [31:0]          ms_type;
   typedef logic [7:0]           count_type;
   typedef logic signed [1:0]    dir_type;

   localparam dir_type   DirZero = 2'sd0;

   localparam ms_type    SampleGap   = 32'd2;
   localparam count_type HoldSamples = 8'd40;
   localparam count_type CountMax    = 8'd255;

   localparam sample_type   CentreReset      = sample_type'(512);
   localparam deadzone_type DeadzoneReset    = deadzone_type'(100);
   localparam wait_type     InitialWaitReset = 16'd300;
   localparam wait_type     RepeatWaitReset  = 16'd100;

endpackage

`default_nettype wire

>>> src/jdar_if.sv
// Request and response channel interfaces (valid/ready with payload).
// Depends on jdar_pkg.
`default_nettype none

interface jdar_req_if;
   logic                 valid;
   logic                 ready;
   logic                 opcode;
   jdar_pkg::sample_type x_sample;
   jdar_pkg::sample_type y_sample;
   jdar_pkg::ms_type     now_ms;
   logic                 hold_value;

   modport source (output valid, output opcode, output x_sample, output y_sample,
                   output now_ms, output hold_value, input ready);
   modport sink   (input valid, input opcode, input x_sample, input y_sample,
                   input now_ms, input hold_value, output ready);
endinterface

interface jdar_rsp_if;
   logic              valid;
   logic              ready;
   logic              move;
   jdar_pkg::dir_type dir_x;
   jdar_pkg::dir_type dir_y;

   modport source (output valid, output move, output dir_x, output dir_y, input ready);
   modport sink   (input valid, input move, input dir_x, input dir_y, output ready);
endinterface

`default_nettype wire

>>> src/jdar_classify.sv
// Classifies one axis sample against centre +/- dead zone into -1, 0, +1.
// Depends on jdar_pkg.
`default_nettype none

module jdar_classify (
   input  var jdar_pkg::sample_type   sample,
   input  var jdar_pkg::sample_type   centre,
   input  var jdar_pkg::deadzone_type deadzone,
   output var jdar_pkg::dir_type      dir
);
   import jdar_pkg::*;

   logic [AdcBits:0] sample_w;
   logic [AdcBits:0] centre_w;
   logic [AdcBits:0] dz_w;
   logic             above;
   logic             below;

   // One extra bit: centre + dz never wraps, and s < c - d is done as s + d < c
   assign sample_w = {1'b0, sample};
   assign centre_w = {1'b0, centre};
   assign dz_w     = {2'b0, deadzone};
   assign above    = sample_w > (centre_w + dz_w);
   assign below    = (sample_w + dz_w) < centre_w;

   always_comb begin
      if (above) begin
         dir = 2'sd1;
      end else if (below) begin
         dir = -2'sd1;
      end else begin
         dir = DirZero;
      end
   end

endmodule

`default_nettype wire

>>> src/joystick_deadzone_autorepeat_unit.sv
// Top level of the joystick dead-zone classifier with hold detection and auto-repeat.
// Depends on jdar_pkg, jdar_req_if/jdar_rsp_if and jdar_classify.
//
// Usage:
//   req_chan carries one item per handshake: opcode (evaluate or set-hold), X and Y
//   samples, the current millisecond time and the hold flag for set-hold.
//   rsp_chan returns exactly one item per request: move, dir_x, dir_y.
//   csr_we/csr_index/csr_wdata write the six configuration registers (centres,
//   dead zones, initial and repeat waits); write only while the unit is idle.
// Timing:
//   An accepted item lands in an input register; once the result register is free it
//   is classified, the hold/repeat state is updated and the result register is
//   loaded. One item per cycle is sustained while rsp_chan.ready stays high, since
//   the state update finishes in the same cycle it is read.
// Reset (synchronous, active high) empties both registers, restores the register
//   defaults and clears the hold state.
// Stalls: while rsp_chan.ready is low the result holds, the input register
//   still fills once, and req_chan.ready drops when both are occupied.
`default_nettype none

module joystick_deadzone_autorepeat_unit (
   input  var logic                            clock,
   input  var logic                            reset,
   jdar_req_if.sink                            req_chan,
   jdar_rsp_if.source                          rsp_chan,
   input  var logic                            csr_we,
   input  var logic [jdar_pkg::CsrIndexBits-1:0] csr_index,
   input  var logic [jdar_pkg::CsrDataBits-1:0]  csr_wdata
);
   import jdar_pkg::*;

   // Configuration
   sample_type   centre_x_ff, centre_y_ff;
   deadzone_type deadzone_x_ff, deadzone_y_ff;
   wait_type     initial_wait_ff, repeat_wait_ff;

   // Input register
   logic       s1_valid_ff;
   logic       s1_opcode_ff;
   sample_type s1_x_ff, s1_y_ff;
   ms_type     s1_now_ff;
   logic       s1_hold_value_ff;

   // Result register
   logic    out_valid_ff;
   logic    out_move_ff, out_move_in;
   dir_type out_dir_x_ff, out_dir_x_in;
   dir_type out_dir_y_ff, out_dir_y_in;

   // Hold / repeat state
   dir_type   last_dir_x_ff, last_dir_x_in;
   dir_type   last_dir_y_ff, last_dir_y_in;
   logic      holding_ff, holding_in;
   count_type stable_count_ff, stable_count_in;
   wait_type  current_wait_ff, current_wait_in;
   ms_type    last_move_time_ff, last_move_time_in;
   ms_type    last_sample_time_ff, last_sample_time_in;

   logic    out_free;
   logic    advance;
   logic    req_take;
   dir_type raw_x, new_x, new_y;
   logic    same_dir;
   logic    sample_due;
   logic    repeat_due;
   logic    hold_start;
   ms_type  move_time_mid;
   count_type count_mid;

   assign out_free = !out_valid_ff || rsp_chan.ready;
   assign advance  = s1_valid_ff && out_free;
   assign req_chan.ready = !s1_valid_ff || out_free;
   assign req_take = req_chan.valid && req_chan.ready;

   assign rsp_chan.valid = out_valid_ff;
   assign rsp_chan.move  = out_move_ff;
   assign rsp_chan.dir_x = out_dir_x_ff;
   assign rsp_chan.dir_y = out_dir_y_ff;

   jdar_classify u_class_x (
      .sample   (s1_x_ff),
      .centre   (centre_x_ff),
      .deadzone (deadzone_x_ff),
      .dir      (raw_x)
   );

   jdar_classify u_class_y (
      .sample   (s1_y_ff),
      .centre   (centre_y_ff),
      .deadzone (deadzone_y_ff),
      .dir      (new_y)
   );

   // X axis is inverted: a high sample means -1
   assign new_x = -raw_x;

   assign same_dir = (new_x == last_dir_x_ff) && (new_y == last_dir_y_ff)
                     && ((new_x != DirZero) || (new_y != DirZero));
   assign sample_due = s1_now_ff >= (last_sample_time_ff + SampleGap);

   always_comb begin
      count_mid = stable_count_ff;
      if (sample_due && !holding_ff && (stable_count_ff < CountMax)) begin
         count_mid = stable_count_ff + 8'd1;
      end
   end

   assign hold_start    = !holding_ff && (count_mid > HoldSamples);
   assign move_time_mid = hold_start ? s1_now_ff : last_move_time_ff;
   // Repeat check sees the move time just set by a hold start
   assign repeat_due    = s1_now_ff >= (move_time_mid + {16'd0, current_wait_ff});

   always_comb begin
      last_dir_x_in       = last_dir_x_ff;
      last_dir_y_in       = last_dir_y_ff;
      holding_in          = holding_ff;
      stable_count_in     = stable_count_ff;
      current_wait_in     = current_wait_ff;
      last_move_time_in   = last_move_time_ff;
      last_sample_time_in = last_sample_time_ff;
      out_move_in         = 1'b0;
      out_dir_x_in        = last_dir_x_ff;
      out_dir_y_in        = last_dir_y_ff;
      if (s1_opcode_ff == OpSetHold) begin
         holding_in      = s1_hold_value_ff;
         stable_count_in = '0;
         current_wait_in = initial_wait_ff;
      end else begin
         out_dir_x_in  = new_x;
         out_dir_y_in  = new_y;
         last_dir_x_in = new_x;
         last_dir_y_in = new_y;
         if (same_dir) begin
            stable_count_in   = count_mid;
            last_move_time_in = move_time_mid;
            if (sample_due) begin
               last_sample_time_in = s1_now_ff;
            end
            if (hold_start) begin
               holding_in  = 1'b1;
               out_move_in = 1'b1;
            end
            if ((holding_ff || hold_start) && repeat_due) begin
               out_move_in       = 1'b1;
               last_move_time_in = s1_now_ff;
               current_wait_in   = repeat_wait_ff;
            end
         end else begin
            holding_in      = 1'b0;
            stable_count_in = '0;
            current_wait_in = initial_wait_ff;
         end
      end
   end

   // Control, state and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff         <= 1'b0;
         out_valid_ff        <= 1'b0;
         last_dir_x_ff       <= DirZero;
         last_dir_y_ff       <= DirZero;
         holding_ff          <= 1'b0;
         stable_count_ff     <= '0;
         current_wait_ff     <= InitialWaitReset;
         last_move_time_ff   <= '0;
         last_sample_time_ff <= '0;
         centre_x_ff         <= CentreReset;
         centre_y_ff         <= CentreReset;
         deadzone_x_ff       <= DeadzoneReset;
         deadzone_y_ff       <= DeadzoneReset;
         initial_wait_ff     <= InitialWaitReset;
         repeat_wait_ff      <= RepeatWaitReset;
      end else begin
         if (req_take) begin
            s1_valid_ff <= 1'b1;
         end else if (advance) begin
            s1_valid_ff <= 1'b0;
         end
         if (advance) begin
            out_valid_ff        <= 1'b1;
            last_dir_x_ff       <= last_dir_x_in;
            last_dir_y_ff       <= last_dir_y_in;
            holding_ff          <= holding_in;
            stable_count_ff     <= stable_count_in;
            current_wait_ff     <= current_wait_in;
            last_move_time_ff   <= last_move_time_in;
            last_sample_time_ff <= last_sample_time_in;
         end else if (rsp_chan.ready) begin
            out_valid_ff <= 1'b0;
         end
         if (csr_we) begin
            case (csr_index)
               CsrCentreX:     centre_x_ff     <= csr_wdata[AdcBits-1:0];
               CsrCentreY:     centre_y_ff     <= csr_wdata[AdcBits-1:0];
               CsrDeadzoneX:   deadzone_x_ff   <= csr_wdata[AdcBits-2:0];
               CsrDeadzoneY:   deadzone_y_ff   <= csr_wdata[AdcBits-2:0];
               CsrInitialWait: initial_wait_ff <= csr_wdata;
               CsrRepeatWait:  repeat_wait_ff  <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_opcode_ff     <= req_chan.opcode;
         s1_x_ff          <= req_chan.x_sample;
         s1_y_ff          <= req_chan.y_sample;
         s1_now_ff        <= req_chan.now_ms;
         s1_hold_value_ff <= req_chan.hold_value;
      end
      if (advance) begin
         out_move_ff  <= out_move_in;
         out_dir_x_ff <= out_dir_x_in;
         out_dir_y_ff <= out_dir_y_in;
      end
   end

endmodule

`default_nettype wire
